### rtl/trle_pkg.sv
// ---------------------------------------------------------------------------
// trle_pkg
// Shared types and constants of the truecolor run-length pixel decoder.
// ---------------------------------------------------------------------------
package trle_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PIXEL_BYTES  = 2'd2;

    localparam int unsigned CFG_DATA_W = 16;

    // packet header fields
    localparam logic [7:0] HDR_RUN_MASK   = 8'h80;
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;

    // reset value of the bytes-per-pixel register, and its four-byte code
    localparam logic [2:0] PIXEL_BYTES_RESET = 3'd3;
    localparam logic [2:0] PIXEL_BYTES_FOUR  = 3'd4;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // decoder phase, one-hot
    typedef enum logic [2:0] {
        PHASE_HEADER = 3'b001,
        PHASE_PIXEL  = 3'b010,
        PHASE_HALTED = 3'b100
    } phase_t;

    // image settings seen by the decoder
    typedef struct packed {
        logic [31:0] total_pixels;
        logic        four_bytes;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic        pixel_valid;
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        image_done;
        logic [1:0]  decode_status;
    } result_t;

endpackage

### rtl/trle_byte_if.sv
// ---------------------------------------------------------------------------
// trle_byte_if
// Coded byte channel: valid/ready handshake with one stream byte per item.
// ---------------------------------------------------------------------------
interface trle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/trle_pixel_if.sv
// ---------------------------------------------------------------------------
// trle_pixel_if
// Pixel result channel: valid/ready handshake with one pixel or end item.
// ---------------------------------------------------------------------------
interface trle_pixel_if;
    logic        valid;
    logic        ready;
    logic        pixel_valid;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic [1:0]  decode_status;

    modport source (output valid, output pixel_valid, output pixel_value,
                    output repeat_count, output image_done, output decode_status,
                    input ready);
    modport sink   (input valid, input pixel_valid, input pixel_value,
                    input repeat_count, input image_done, input decode_status,
                    output ready);
endinterface

### rtl/trle_cfg.sv
// ---------------------------------------------------------------------------
// trle_cfg
// Configuration registers; keeps width*height as a ready product.
// ---------------------------------------------------------------------------
module trle_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [trle_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output trle_pkg::cfg_t                 cfg
);

    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [2:0]  pbytes_reg;
    logic [31:0] total_reg;

    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic        dim_write;

    // product operands take the value being written
    always_comb
    begin
        mul_a     = width_reg;
        mul_b     = height_reg;
        dim_write = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                trle_pkg::CFG_IMAGE_WIDTH:
                begin
                    mul_a     = cfg_wdata[15:0];
                    dim_write = 1'b1;
                end
                trle_pkg::CFG_IMAGE_HEIGHT:
                begin
                    mul_b     = cfg_wdata[15:0];
                    dim_write = 1'b1;
                end
                default:
                begin
                    dim_write = 1'b0;
                end
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            pbytes_reg <= trle_pkg::PIXEL_BYTES_RESET;
            total_reg  <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == trle_pkg::CFG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_wdata[15:0];
            end
            if (cfg_we && cfg_index == trle_pkg::CFG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_wdata[15:0];
            end
            if (cfg_we && cfg_index == trle_pkg::CFG_PIXEL_BYTES)
            begin
                pbytes_reg <= cfg_wdata[2:0];
            end
            if (dim_write)
            begin
                total_reg <= 32'(mul_a * mul_b);
            end
        end
    end

    assign cfg.total_pixels = total_reg;
    assign cfg.four_bytes   = (pbytes_reg == trle_pkg::PIXEL_BYTES_FOUR);

endmodule

### rtl/trle_front.sv
// ---------------------------------------------------------------------------
// trle_front
// Accepts coded bytes, tracks packets and pixel assembly, and builds results.
// ---------------------------------------------------------------------------
module trle_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  trle_pkg::cfg_t    cfg,
    trle_byte_if.sink         byte_in,
    input  logic              q_full,
    output logic              q_push,
    output trle_pkg::result_t q_data
);

    trle_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  remain_reg, remain_next;
    logic        run_reg, run_next;
    logic [1:0]  bip_reg, bip_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] pw_reg, pw_next;
    logic        ovf_reg, ovf_next;

    logic        accept;
    logic [7:0]  b;
    logic        image_full;
    logic [31:0] missing;
    logic [7:0]  count;
    logic [31:0] asm_merged;
    logic [1:0]  bip_inc;
    logic        pixel_done;
    logic [7:0]  rep;
    logic        emit;

    assign byte_in.ready = !q_full;
    assign accept        = byte_in.valid && !q_full;
    assign b             = byte_in.data_byte;

    // pixels still missing
    assign image_full = (pw_reg >= cfg.total_pixels);
    assign missing    = image_full ? 32'd0 : (cfg.total_pixels - pw_reg);
    assign count      = (b & trle_pkg::HDR_COUNT_MASK) + 8'd1;

    // merge byte into the pixel under assembly
    always_comb
    begin
        case (bip_reg)
            2'd0:    asm_merged = asm_reg | {24'd0, b};
            2'd1:    asm_merged = asm_reg | {16'd0, b, 8'd0};
            2'd2:    asm_merged = asm_reg | {8'd0, b, 16'd0};
            default: asm_merged = asm_reg | {b, 24'd0};
        endcase
    end

    assign bip_inc    = bip_reg + 2'd1;
    assign pixel_done = (bip_inc == 2'd0) || (!cfg.four_bytes && bip_inc == 2'd3);

    // decode step
    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        run_next    = run_reg;
        bip_next    = bip_reg;
        asm_next    = asm_reg;
        pw_next     = pw_reg;
        ovf_next    = ovf_reg;
        rep         = 8'd0;
        q_data      = '0;

        if (phase_reg == trle_pkg::PHASE_HALTED || image_full)
        begin
            // byte ignored
        end
        else if (phase_reg == trle_pkg::PHASE_HEADER)
        begin
            if ((b & trle_pkg::HDR_RUN_MASK) != 8'd0)
            begin
                run_next    = 1'b1;
                remain_next = count;
                phase_next  = trle_pkg::PHASE_PIXEL;
            end
            else if ({24'd0, count} > missing)
            begin
                ovf_next   = 1'b1;
                phase_next = trle_pkg::PHASE_HALTED;
            end
            else
            begin
                run_next    = 1'b0;
                remain_next = count;
                phase_next  = trle_pkg::PHASE_PIXEL;
            end
            bip_next = 2'd0;
            asm_next = '0;
        end
        else
        begin
            bip_next = bip_inc;
            asm_next = asm_merged;
            if (pixel_done)
            begin
                q_data.pixel_valid = 1'b1;
                q_data.pixel_value = asm_merged;
                if (run_reg)
                begin
                    rep         = ({24'd0, remain_reg} > missing) ? missing[7:0]
                                                                  : remain_reg;
                    remain_next = 8'd0;
                    phase_next  = trle_pkg::PHASE_HEADER;
                end
                else
                begin
                    rep         = 8'd1;
                    remain_next = remain_reg - 8'd1;
                    if (remain_next == 8'd0)
                    begin
                        phase_next = trle_pkg::PHASE_HEADER;
                    end
                end
                q_data.repeat_count = rep;
                pw_next  = pw_reg + {24'd0, rep};
                bip_next = 2'd0;
                asm_next = '0;
            end
        end

        // end of image closes with a status
        if (byte_in.last_byte)
        begin
            q_data.image_done = 1'b1;
            if (ovf_next)
            begin
                q_data.decode_status = trle_pkg::STATUS_OVERFLOW;
            end
            else if (pw_next == cfg.total_pixels)
            begin
                q_data.decode_status = trle_pkg::STATUS_OK;
            end
            else
            begin
                q_data.decode_status = trle_pkg::STATUS_SHORT;
            end
        end
    end

    assign emit   = q_data.pixel_valid || byte_in.last_byte;
    assign q_push = accept && emit;

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= trle_pkg::PHASE_HEADER;
            remain_reg <= '0;
            run_reg    <= 1'b0;
            bip_reg    <= '0;
            asm_reg    <= '0;
            pw_reg     <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (byte_in.last_byte)
            begin
                phase_reg  <= trle_pkg::PHASE_HEADER;
                remain_reg <= '0;
                run_reg    <= 1'b0;
                bip_reg    <= '0;
                asm_reg    <= '0;
                pw_reg     <= '0;
                ovf_reg    <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                remain_reg <= remain_next;
                run_reg    <= run_next;
                bip_reg    <= bip_next;
                asm_reg    <= asm_next;
                pw_reg     <= pw_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

endmodule

### rtl/trle_queue.sv
// ---------------------------------------------------------------------------
// trle_queue
// Two-entry result queue between the decoder and the output stage.
// ---------------------------------------------------------------------------
module trle_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  trle_pkg::result_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output trle_pkg::result_t head_data
);

    trle_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### rtl/trle_back.sv
// ---------------------------------------------------------------------------
// trle_back
// Output register stage: drains the queue onto the pixel channel.
// ---------------------------------------------------------------------------
module trle_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  trle_pkg::result_t head_data,
    output logic              pop,
    trle_pixel_if.source      pixel_out
);

    logic              out_valid_reg;
    trle_pkg::result_t out_data_reg;
    logic              load;

    // the register takes a new item when empty or being emptied
    assign load = !out_valid_reg || pixel_out.ready;
    assign pop  = load && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= head_data;
        end
    end

    assign pixel_out.valid         = out_valid_reg;
    assign pixel_out.pixel_valid   = out_data_reg.pixel_valid;
    assign pixel_out.pixel_value   = out_data_reg.pixel_value;
    assign pixel_out.repeat_count  = out_data_reg.repeat_count;
    assign pixel_out.image_done    = out_data_reg.image_done;
    assign pixel_out.decode_status = out_data_reg.decode_status;

endmodule

### rtl/truecolor_rle_pixel_decoder.sv
// ---------------------------------------------------------------------------
// truecolor_rle_pixel_decoder
// Run-length pixel decoder for truecolor images, one coded byte per item.
//
//   channel    dir   handshake            contents
//   byte_in    in    valid/ready          data_byte, last_byte
//   pixel_out  out   valid/ready          pixel_valid, pixel_value,
//                                         repeat_count, image_done,
//                                         decode_status
//   cfg        in    cfg_we (no ready)    cfg_index, cfg_wdata
//
// One byte is taken every cycle unless the queue is full; the packet state and
// pixel count update on each accepted byte. A result is written to the queue on
// the edge that takes its byte, then passes through the output register to pixel_out.
// byte_in stalls only when the two-entry queue is full. No clearing pass
// after reset; width*height is updated on the configuration write itself.
// ---------------------------------------------------------------------------
module truecolor_rle_pixel_decoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    trle_byte_if.sink                       byte_in,
    trle_pixel_if.source                    pixel_out,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [trle_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    trle_pkg::cfg_t    cfg;
    trle_pkg::result_t q_push_data;
    trle_pkg::result_t q_head_data;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_head_valid;

    // configuration registers
    trle_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // byte decoder
    trle_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .byte_in (byte_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_push_data)
    );

    // result queue
    trle_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    // output stage
    trle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop),
        .pixel_out  (pixel_out)
    );

endmodule

### tb/truecolor_rle_pixel_decoder_test.sv
// ---------------------------------------------------------------------------
// truecolor_rle_pixel_decoder_test
// Self-checking bench for the run-length pixel decoder. A short directed
// table covers run and literal packets, empty and full images, clipping,
// literal overflow and early stream end. Random coded images follow under
// three sender/receiver stall mixes, each result checked against an
// in-bench decoder model.
// ---------------------------------------------------------------------------
module truecolor_rle_pixel_decoder_test;
    import trle_pkg::*;

    localparam int IDLE_GAP         = 4;
    localparam int BYTES_PER_PHASE  = 310;
    localparam int PLAN_ROWS        = 33;
    localparam int TIMEOUT          = 2_000_000;

    typedef enum logic { ROW_REG, ROW_BYTE } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [15:0] value;
        logic        last;
        logic        typed;
        result_t     want;
    } plan_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } coded_byte_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    trle_byte_if  byte_ch ();
    trle_pixel_if pixel_ch ();

    truecolor_rle_pixel_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_ch),
        .pixel_out (pixel_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // decoder model: registers and packet state
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [2:0]  pix_bytes;
    phase_t      dec_phase;
    logic [7:0]  pkt_left;
    logic        in_run;
    logic [1:0]  byte_idx;
    logic [31:0] px_acc;
    logic [31:0] px_written;
    logic        ovf_seen;

    result_t     results_due[$];
    coded_byte_t stream_q[$];
    plan_row_t   plan[PLAN_ROWS];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int results_checked;
    int bytes_sent;
    int bytes_decoded;
    int images_sent;
    int settings_used;
    int done_ok;
    int done_short;
    int done_ovf;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // hard stop
    initial
    begin
        #TIMEOUT;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void reset_decoder();
        dec_phase  = PHASE_HEADER;
        pkt_left   = '0;
        in_run     = 1'b0;
        byte_idx   = '0;
        px_acc     = '0;
        px_written = '0;
        ovf_seen   = 1'b0;
    endfunction

    // one coded byte through the model; returns 1 when a result item is due
    function automatic bit decode_byte(input logic [7:0] b, input logic l,
                                       output result_t res, output bit used);
        logic [63:0] total;
        logic [63:0] missing;
        logic [63:0] rep;
        logic [7:0]  count;
        int unsigned bpp;
        bit          got;
        total   = 64'(img_w) * 64'(img_h);
        bpp     = (pix_bytes == PIXEL_BYTES_FOUR) ? 4 : 3;
        missing = (64'(px_written) < total) ? total - 64'(px_written) : 64'd0;
        res     = '0;
        used    = 1'b0;
        got     = 1'b0;
        if (dec_phase == PHASE_HALTED || missing == 0)
        begin
            // image full or stream halted: byte dropped
        end
        else if (dec_phase == PHASE_HEADER)
        begin
            used  = 1'b1;
            count = (b & HDR_COUNT_MASK) + 8'd1;
            if ((b & HDR_RUN_MASK) != 0)
            begin
                in_run    = 1'b1;
                pkt_left  = count;
                dec_phase = PHASE_PIXEL;
            end
            else if (64'(count) > missing)
            begin
                ovf_seen  = 1'b1;
                dec_phase = PHASE_HALTED;
            end
            else
            begin
                in_run    = 1'b0;
                pkt_left  = count;
                dec_phase = PHASE_PIXEL;
            end
            byte_idx = '0;
            px_acc   = '0;
        end
        else
        begin
            used     = 1'b1;
            px_acc   = px_acc | (32'(b) << (8 * byte_idx));
            byte_idx = byte_idx + 2'd1;
            if (byte_idx >= bpp || byte_idx == 0)
            begin
                if (in_run)
                begin
                    rep = 64'(pkt_left);
                    if (rep > missing)
                        rep = missing;
                    pkt_left  = '0;
                    dec_phase = PHASE_HEADER;
                end
                else
                begin
                    rep      = 64'd1;
                    pkt_left = pkt_left - 8'd1;
                    if (pkt_left == 0)
                        dec_phase = PHASE_HEADER;
                end
                px_written       = px_written + 32'(rep);
                res.pixel_valid  = 1'b1;
                res.pixel_value  = px_acc;
                res.repeat_count = rep[7:0];
                got              = 1'b1;
                byte_idx         = '0;
                px_acc           = '0;
            end
        end
        // end of stream closes the image
        if (l)
        begin
            res.image_done = 1'b1;
            if (ovf_seen)
                res.decode_status = STATUS_OVERFLOW;
            else if (64'(px_written) == total)
                res.decode_status = STATUS_OK;
            else
                res.decode_status = STATUS_SHORT;
            got = 1'b1;
            reset_decoder();
        end
        return got;
    endfunction

    // directed table rows
    function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [15:0] v);
        plan_row_t r;
        r         = '{kind: ROW_REG, default: '0};
        r.reg_idx = idx;
        r.value   = v;
        return r;
    endfunction

    function automatic plan_row_t byte_row(input logic [7:0] b, input logic l);
        plan_row_t r;
        r       = '{kind: ROW_BYTE, default: '0};
        r.value = 16'(b);
        r.last  = l;
        return r;
    endfunction

    function automatic plan_row_t byte_row_want(input logic [7:0] b, input logic l,
                                                input logic pv, input logic [31:0] pval,
                                                input logic [7:0] rep, input status_t st);
        plan_row_t r;
        r                    = byte_row(b, l);
        r.typed              = 1'b1;
        r.want.pixel_valid   = pv;
        r.want.pixel_value   = pval;
        r.want.repeat_count  = rep;
        r.want.image_done    = l;
        r.want.decode_status = st;
        return r;
    endfunction

    // drive one coded byte and book its expected result
    task automatic send_byte(input logic [7:0] b, input logic l,
                             input logic typed, input result_t want);
        result_t res;
        bit      got;
        bit      used;
        if ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= l;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        got = decode_byte(b, l, res, used);
        bytes_sent++;
        if (used)
            bytes_decoded++;
        if (typed)
            results_due.push_back(want);
        else if (got)
            results_due.push_back(res);
    endtask

    // hold off until every result is out and the pipe has settled
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:  img_w = v;
            CFG_IMAGE_HEIGHT: img_h = v;
            CFG_PIXEL_BYTES:  pix_bytes = v[2:0];
            default: ;
        endcase
    endtask

    task automatic set_image(input logic [15:0] w, input logic [15:0] h, input logic [2:0] pb);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_PIXEL_BYTES, 16'(pb));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic void push_byte(input logic [7:0] b);
        coded_byte_t c;
        c.data = b;
        c.last = 1'b0;
        stream_q.push_back(c);
    endfunction

    function automatic void push_pixel(input int bpp);
        repeat (bpp) push_byte(8'($urandom));
    endfunction

    // dimension: mostly tiny, sometimes the extremes or anything
    function automatic logic [15:0] pick_dim();
        case ($urandom_range(19))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 16'hFFFF));
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    // coded stream of one image: mostly well formed, some broken or noise
    task automatic build_image(input logic [63:0] total, input int bpp);
        int     kind;
        longint rem;
        int     n;
        int     lim;
        int     max_pk;
        int     pk;
        kind   = $urandom_range(99);
        rem    = longint'(total);
        max_pk = (total > 64) ? $urandom_range(1, 6) : 1000;
        pk     = 0;
        stream_q.delete();
        while (rem > 0 && pk < max_pk)
        begin
            pk++;
            lim = (rem < 128) ? int'(rem) : 128;
            if (kind >= 80 && kind < 88 && rem < 128 && $urandom_range(1) == 0)
            begin
                // literal packet longer than the pixels still missing
                n = $urandom_range(int'(rem) + 1, 128);
                push_byte(8'(n - 1));
                repeat ($urandom_range(0, 4)) push_byte(8'($urandom));
                break;
            end
            else if ($urandom_range(1) == 1)
            begin
                n = ($urandom_range(3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, lim);
                push_byte(HDR_RUN_MASK | 8'(n - 1));
                push_pixel(bpp);
                rem = rem - ((n > rem) ? rem : longint'(n));
            end
            else
            begin
                if ($urandom_range(7) == 0 || lim <= 8)
                    n = $urandom_range(1, lim);
                else
                    n = $urandom_range(1, 8);
                push_byte(8'(n - 1));
                repeat (n) push_pixel(bpp);
                rem = rem - longint'(n);
            end
        end
        // broken tails and noise
        if (kind >= 70 && kind < 80 && stream_q.size() > 0)
            repeat ($urandom_range(1, stream_q.size())) void'(stream_q.pop_back());
        if (kind >= 88 && kind < 94)
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
        if (kind >= 94)
        begin
            stream_q.delete();
            repeat ($urandom_range(1, 20)) push_byte(8'($urandom));
        end
        if (stream_q.size() == 0)
            push_byte(8'($urandom));
        stream_q[stream_q.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // receiver stalls
    always @(posedge clk)
        pixel_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // result items against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result item with nothing expected");
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                results_checked++;
                check_field("pixel_valid", 32'(want.pixel_valid), 32'(pixel_ch.pixel_valid));
                check_field("pixel_value", want.pixel_value, pixel_ch.pixel_value);
                check_field("repeat_count", 32'(want.repeat_count), 32'(pixel_ch.repeat_count));
                check_field("image_done", 32'(want.image_done), 32'(pixel_ch.image_done));
                check_field("decode_status", 32'(want.decode_status),
                            32'(pixel_ch.decode_status));
                if (want.image_done)
                begin
                    if (want.decode_status == STATUS_OK)
                        done_ok++;
                    else if (want.decode_status == STATUS_SHORT)
                        done_short++;
                    else
                        done_ovf++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [15:0] w;
        logic [15:0] h;
        logic [2:0]  pb;
        logic        in_cfg;
        int          goal;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        img_w             = '0;
        img_h             = '0;
        pix_bytes         = PIXEL_BYTES_RESET;
        reset_decoder();
        send_idle_pct     = 37;
        recv_idle_pct     = 79;
        mismatches        = 0;
        results_checked   = 0;
        bytes_sent        = 0;
        bytes_decoded     = 0;
        images_sent       = 0;
        settings_used     = 0;
        done_ok           = 0;
        done_short        = 0;
        done_ovf          = 0;
        in_cfg            = 1'b0;

        plan = '{
            // empty image right after reset
            byte_row_want(8'h00, 1'b1, 1'b0, 32'h0, 8'd0, STATUS_OK),
            // 2x1, odd bytes-per-pixel code meaning three
            reg_row(CFG_IMAGE_WIDTH, 16'd2),
            reg_row(CFG_IMAGE_HEIGHT, 16'd1),
            reg_row(CFG_PIXEL_BYTES, 16'd0),
            byte_row(8'h81, 1'b0),
            byte_row(8'hFF, 1'b0),
            byte_row(8'h00, 1'b0),
            byte_row_want(8'h7F, 1'b0, 1'b1, 32'h007F00FF, 8'd2, STATUS_OK),
            // byte after a full image is dropped
            byte_row_want(8'hAA, 1'b1, 1'b0, 32'h0, 8'd0, STATUS_OK),
            // largest image, four-byte pixels, stream ends early
            reg_row(CFG_PIXEL_BYTES, 16'(PIXEL_BYTES_FOUR)),
            reg_row(CFG_IMAGE_WIDTH, 16'hFFFF),
            reg_row(CFG_IMAGE_HEIGHT, 16'hFFFF),
            byte_row(8'h00, 1'b0),
            byte_row(8'h01, 1'b0),
            byte_row(8'h02, 1'b0),
            byte_row(8'h03, 1'b0),
            byte_row_want(8'h80, 1'b0, 1'b1, 32'h80030201, 8'd1, STATUS_OK),
            byte_row(8'hFF, 1'b0),
            byte_row(8'hFF, 1'b0),
            byte_row(8'hFF, 1'b0),
            byte_row(8'hFF, 1'b0),
            byte_row(8'hFF, 1'b0),
            byte_row(8'h7F, 1'b0),
            byte_row_want(8'h12, 1'b1, 1'b0, 32'h0, 8'd0, STATUS_SHORT),
            // 1x3: literal overflow, then a run clipped to the image
            reg_row(CFG_IMAGE_WIDTH, 16'd1),
            reg_row(CFG_IMAGE_HEIGHT, 16'd3),
            reg_row(CFG_PIXEL_BYTES, 16'd7),
            byte_row(8'h03, 1'b0),
            byte_row_want(8'h55, 1'b1, 1'b0, 32'h0, 8'd0, STATUS_OVERFLOW),
            byte_row(8'hFF, 1'b0),
            byte_row(8'h11, 1'b0),
            byte_row(8'h22, 1'b0),
            byte_row_want(8'h33, 1'b1, 1'b1, 32'h00332211, 8'd3, STATUS_OK)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                if (!in_cfg)
                begin
                    wait_idle();
                    in_cfg = 1'b1;
                    settings_used++;
                end
                write_reg(plan[i].reg_idx, plan[i].value);
            end
            else
            begin
                if (in_cfg)
                begin
                    cfg_we <= 1'b0;
                    in_cfg = 1'b0;
                end
                send_byte(plan[i].value[7:0], plan[i].last, plan[i].typed, plan[i].want);
            end
        end

        // random images under three stall mixes
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 79 : 0;
            recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 37 : 0;
            goal = bytes_decoded + BYTES_PER_PHASE;
            while (bytes_decoded < goal)
            begin
                w  = pick_dim();
                h  = pick_dim();
                pb = ($urandom_range(3) == 0) ? 3'($urandom_range(7))
                   : ($urandom_range(1) == 1) ? PIXEL_BYTES_RESET : PIXEL_BYTES_FOUR;
                set_image(w, h, pb);
                repeat ($urandom_range(1, 4))
                begin
                    build_image(64'(w) * 64'(h), (pb == PIXEL_BYTES_FOUR) ? 4 : 3);
                    foreach (stream_q[j])
                        send_byte(stream_q[j].data, stream_q[j].last, 1'b0, '0);
                    images_sent++;
                end
            end
        end

        // drain
        byte_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run: %0d coded bytes (%0d decoded), %0d random images, %0d settings",
                 bytes_sent, bytes_decoded, images_sent, settings_used);
        $display("run: %0d result items checked; images ok %0d, short %0d, overflow %0d",
                 results_checked, done_ok, done_short, done_ovf);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/trle_pkg.sv
rtl/trle_byte_if.sv
rtl/trle_pixel_if.sv
rtl/trle_cfg.sv
rtl/trle_front.sv
rtl/trle_queue.sv
rtl/trle_back.sv
rtl/truecolor_rle_pixel_decoder.sv
tb/truecolor_rle_pixel_decoder_test.sv
